[design/ps2mt_pkg.sv]
// Shared types and constants for the PS/2 mouse cursor tracker.
package ps2mt_pkg;

  localparam int CFG_W      = 13;
  localparam int BYTE_W     = 8;
  localparam int DELTA_W    = 9;
  localparam int BTN_W      = 3;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  // header byte fields
  localparam logic [7:0] HDR_SYNC  = 8'h08;
  localparam logic [7:0] HDR_OVF   = 8'hC0;
  localparam logic [7:0] HDR_XSIGN = 8'h10;
  localparam logic [7:0] HDR_YSIGN = 8'h20;
  localparam logic [7:0] HDR_BTN   = 8'h07;

  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_XMOVE = 2'd1,
    PH_YMOVE = 2'd2
  } phase_t;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                      valid;
    logic [BTN_W-1:0]          buttons;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } pkt_t;

endpackage

[design/ps2mt_decode.sv]
// Byte framer: phase tracking, header sync and packet assembly.
module ps2mt_decode (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              data,
  output ps2mt_pkg::pkt_t         pkt
);
  import ps2mt_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] xmove_r, xmove_nxt;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    xmove_nxt  = xmove_r;
    unique case (phase_r)
      PH_XMOVE: begin
        xmove_nxt = data;
        phase_nxt = PH_YMOVE;
      end
      PH_YMOVE: begin
        phase_nxt = PH_HEAD;
      end
      default: begin
        // resync: only a byte with the always-one bit can open a packet
        if ((data & HDR_SYNC) != 8'h00) begin
          header_nxt = data;
          phase_nxt  = PH_XMOVE;
        end else begin
          phase_nxt  = PH_HEAD;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    pkt.valid   = (phase_r == PH_YMOVE) && ((header_r & HDR_OVF) == 8'h00);
    pkt.buttons = BTN_W'(header_r & HDR_BTN);
    pkt.dx      = {((header_r & HDR_XSIGN) != 8'h00), xmove_r};
    pkt.dy      = {((header_r & HDR_YSIGN) != 8'h00), data};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      header_r <= header_nxt;
      xmove_r  <= xmove_nxt;
    end
  end

endmodule

[design/ps2mt_cursor.sv]
// Cursor position registers with per-axis clamp to the screen size.
module ps2mt_cursor #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  ps2mt_pkg::pkt_t              pkt,
  input  logic [ps2mt_pkg::CFG_W-1:0]  width,
  input  logic [ps2mt_pkg::CFG_W-1:0]  height,
  output logic [COORD_BITS-1:0]        new_x,
  output logic [COORD_BITS-1:0]        new_y
);
  import ps2mt_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int SW      = (CB + 1 > CFG_W) ? CB + 1 : CFG_W;
  localparam int LIMIT_I = 1 << CB;
  localparam int RST_X   = ((WIDTH_RST > LIMIT_I) ? LIMIT_I : WIDTH_RST) / 2;
  localparam int RST_Y   = ((HEIGHT_RST > LIMIT_I) ? LIMIT_I : HEIGHT_RST) / 2;
  localparam logic [SW-1:0] LIMIT = SW'(1) << CB;

  logic [CB-1:0]        pos_x_r, pos_y_r;
  logic [SW-1:0]        top_x, top_y;
  logic signed [CB+1:0] sum_x, sum_y;

  function automatic logic [SW-1:0] size_top(logic [CFG_W-1:0] r);
    logic [SW-1:0] s;
    s = SW'(r);
    if (s == '0) begin
      s = SW'(1);
    end else if (s > LIMIT) begin
      s = LIMIT;
    end
    return s - SW'(1);
  endfunction

  function automatic logic [CB-1:0] clamp(logic signed [CB+1:0] v, logic [SW-1:0] top);
    logic [CB-1:0] r;
    if (v[CB+1]) begin
      r = '0;
    end else if (SW'(v[CB:0]) > top) begin
      r = top[CB-1:0];
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  assign top_x = size_top(width);
  assign top_y = size_top(height);

  // Y is subtracted: mouse Y grows upward, screen Y downward
  assign sum_x = $signed({2'b00, pos_x_r}) + (CB+2)'(pkt.dx);
  assign sum_y = $signed({2'b00, pos_y_r}) - (CB+2)'(pkt.dy);

  assign new_x = clamp(sum_x, top_x);
  assign new_y = clamp(sum_y, top_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= CB'(RST_X);
      pos_y_r <= CB'(RST_Y);
    end else if (step && pkt.valid) begin
      pos_x_r <= new_x;
      pos_y_r <= new_y;
    end
  end

endmodule

[design/ps2_mouse_packet_cursor_tracker.sv]
// Top level: PS/2 mouse packet decoder driving a clamped cursor.
//
//   channel | dir | payload                                    | handshake
//   in_     | in  | data_byte                                  | tvalid/tready
//   out_    | out | cursor_x, cursor_y, buttons, delta_x, _y   | tvalid/tready
//   cfg_    | in  | index 0 screen_width, 1 screen_height      | valid/ready
//
// One byte per cycle unless the result register stalls: a byte is held in the input
// register, and the framer and cursor adder/clamp load the result register from it.
// A result beat is registered once its last byte leaves the input register.
// Reset (rst_n low, synchronous) centers the cursor on 640x480 and waits
// for a header byte. A stalled result register stops the input register,
// which drops in_tready only once both hold a beat.
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cursor_x, cursor_y, button_bits, delta_x, delta_y from bit 0 up, zero pad
  output logic [((2*COORD_BITS+21+7)/8)*8-1:0] out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [0:0]                          cfg_index,
  input  logic [ps2mt_pkg::CFG_W-1:0]         cfg_data
);
  import ps2mt_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int PAY_W = 2*CB + BTN_W + 2*DELTA_W;
  localparam int OUT_W = ((PAY_W + 7) / 8) * 8;

  logic             s1_valid_r;
  logic [7:0]       s1_data_r;
  logic             adv;
  logic [CFG_W-1:0] width_r, height_r;
  pkt_t             pkt;
  logic [CB-1:0]    new_x, new_y;
  logic             out_valid_r;
  logic [PAY_W-1:0] out_pay_r;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(WIDTH_RST);
      height_r <= CFG_W'(HEIGHT_RST);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
  end

  ps2mt_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .data  (s1_data_r),
    .pkt   (pkt)
  );

  ps2mt_cursor #(
    .COORD_BITS (CB)
  ) u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .pkt    (pkt),
    .width  (width_r),
    .height (height_r),
    .new_x  (new_x),
    .new_y  (new_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pkt.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pkt.valid) begin
      out_pay_r <= {pkt.dy, pkt.dx, pkt.buttons, new_y, new_x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_pay_r);

  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result beat present right after reset");

  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r))
    else $error("result beat without a byte in the input register");

  a_stall_bp: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("byte accepted while both registers are held");

endmodule

[tb/tb_ps2_mouse_packet_cursor_tracker.sv]
// Testbench for the PS/2 mouse packet decoder with a clamped cursor.
module tb_ps2_mouse_packet_cursor_tracker;
  import ps2mt_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int OUT_W      = ((2*COORD_BITS+21+7)/8)*8;
  localparam int CYCLE_CAP  = 300000;
  localparam int ITEMS_PER_PHASE = 290;
  localparam logic [7:0] OVF_X = 8'h40;
  localparam logic [7:0] OVF_Y = 8'h80;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [BTN_W-1:0]      btn;
    logic [DELTA_W-1:0]    dx;
    logic [DELTA_W-1:0]    dy;
  } cursor_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  ps2_mouse_packet_cursor_tracker #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]   mouse_bytes[$];
  cursor_beat_t cursor_due[$];
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  errors = 0;
  int  cycles = 0;
  bit  byte_taken = 1'b0;

  // tracker state mirrored from the block
  phase_t                trk_phase;
  logic [7:0]            trk_hdr;
  logic [7:0]            trk_xbyte;
  logic [COORD_BITS-1:0] trk_x;
  logic [COORD_BITS-1:0] trk_y;
  logic [CFG_W-1:0]      width_reg;
  logic [CFG_W-1:0]      height_reg;

  function automatic int eff_size(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > (1 << COORD_BITS)) return 1 << COORD_BITS;
    return int'(r);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_axis(int v, int size);
    if (v < 0) return '0;
    if (v > size - 1) return COORD_BITS'(size - 1);
    return COORD_BITS'(v);
  endfunction

  function automatic void track_byte(logic [7:0] b);
    int dx, dy;
    cursor_beat_t beat;
    case (trk_phase)
      PH_XMOVE: begin
        trk_xbyte = b;
        trk_phase = PH_YMOVE;
      end
      PH_YMOVE: begin
        trk_phase = PH_HEAD;
        if ((trk_hdr & HDR_OVF) == 0) begin
          dx = int'(trk_xbyte) - (((trk_hdr & HDR_XSIGN) != 0) ? 256 : 0);
          dy = int'(b) - (((trk_hdr & HDR_YSIGN) != 0) ? 256 : 0);
          // PS/2 Y grows upward, screen Y grows downward
          trk_x = clamp_axis(int'(trk_x) + dx, eff_size(width_reg));
          trk_y = clamp_axis(int'(trk_y) - dy, eff_size(height_reg));
          beat.cx  = trk_x;
          beat.cy  = trk_y;
          beat.btn = BTN_W'(trk_hdr & HDR_BTN);
          beat.dx  = dx[DELTA_W-1:0];
          beat.dy  = dy[DELTA_W-1:0];
          cursor_due.push_back(beat);
        end
      end
      default: begin
        if ((b & HDR_SYNC) != 0) begin
          trk_hdr   = b;
          trk_phase = PH_XMOVE;
        end else begin
          trk_phase = PH_HEAD;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
  endtask

  // monitor: input accepts feed the tracker, output beats are checked
  always @(posedge clk) begin
    cursor_beat_t want;
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("[ps2_mouse_packet_cursor_tracker] ERROR");
      $finish;
    end else begin
      byte_taken = rst_n && in_tvalid && in_tready;
      if (byte_taken) track_byte(in_tdata);
      if (rst_n && out_tvalid && out_tready) begin
        if (cursor_due.size() == 0) begin
          report_mismatch("beat with nothing pending", 1, 0);
        end else begin
          want = cursor_due.pop_front();
          if (out_tdata[11:0] != want.cx)
            report_mismatch("cursor_x", int'(out_tdata[11:0]), int'(want.cx));
          if (out_tdata[23:12] != want.cy)
            report_mismatch("cursor_y", int'(out_tdata[23:12]), int'(want.cy));
          if (out_tdata[26:24] != want.btn)
            report_mismatch("button_bits", int'(out_tdata[26:24]), int'(want.btn));
          if (out_tdata[35:27] != want.dx)
            report_mismatch("delta_x", int'(out_tdata[35:27]), int'(want.dx));
          if (out_tdata[44:36] != want.dy)
            report_mismatch("delta_y", int'(out_tdata[44:36]), int'(want.dy));
          if (out_tdata[OUT_W-1:45] != 0)
            report_mismatch("pad", int'(out_tdata[OUT_W-1:45]), 0);
        end
      end
    end
  end

  // driver: byte stream in, random backpressure out
  always @(negedge clk) begin
    if (rst_n && (byte_taken || !in_tvalid)) begin
      if (mouse_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= mouse_bytes.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic push_packet(logic [7:0] h, logic [7:0] x, logic [7:0] y);
    mouse_bytes.push_back(h);
    mouse_bytes.push_back(x);
    mouse_bytes.push_back(y);
  endtask

  task automatic write_size(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_block();
    while (!(mouse_bytes.size() == 0 && !in_tvalid && cursor_due.size() == 0))
      @(posedge clk);
    // trailing header/X bytes give no beat, let the pipeline settle
    repeat (8) @(posedge clk);
  endtask

  task automatic fill_random(int count);
    int added;
    int r;
    logic [7:0] h;
    added = 0;
    while (added < count) begin
      r = $urandom_range(99);
      if (r < 10) begin
        mouse_bytes.push_back(8'($urandom_range(255)));
        added += 1;
      end else if (r < 16) begin
        // packet cut short after the header and X bytes
        mouse_bytes.push_back(8'($urandom_range(255)) | HDR_SYNC);
        mouse_bytes.push_back(8'($urandom_range(255)));
        added += 2;
      end else begin
        h = (8'($urandom_range(255)) & ~HDR_OVF) | HDR_SYNC;
        if ($urandom_range(9) == 0) h = h | (8'($urandom_range(1, 3)) << 6);
        if ($urandom_range(3) == 0)
          push_packet(h, 8'($urandom_range(7)), 8'($urandom_range(7)));
        else
          push_packet(h, 8'($urandom_range(255)), 8'($urandom_range(255)));
        added += 3;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] widths[5];
    logic [CFG_W-1:0] heights[5];
    trk_phase  = PH_HEAD;
    trk_hdr    = '0;
    trk_xbyte  = '0;
    width_reg  = CFG_W'(WIDTH_RST);
    height_reg = CFG_W'(HEIGHT_RST);
    trk_x = COORD_BITS'(eff_size(width_reg) / 2);
    trk_y = COORD_BITS'(eff_size(height_reg) / 2);

    widths[0]  = CFG_W'($urandom_range(1, 4096));
    heights[0] = CFG_W'($urandom_range(1, 4096));
    widths[1]  = '0;   heights[1] = '0;
    widths[2]  = CFG_W'(4096); heights[2] = CFG_W'(4096);
    widths[3]  = '1;   heights[3] = CFG_W'(3);
    widths[4]  = CFG_W'(5);    heights[4] = '1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: bytes without the sync bit, sign extremes, clamps, overflow drops
    mouse_bytes.push_back(8'h00);
    mouse_bytes.push_back(~HDR_SYNC);
    push_packet(HDR_SYNC, 8'h00, 8'h00);
    push_packet(HDR_SYNC | HDR_BTN, 8'hFF, 8'h00);
    push_packet(HDR_SYNC | HDR_XSIGN | HDR_YSIGN, 8'h00, 8'h00);
    push_packet(HDR_SYNC | OVF_X, 8'h7F, 8'h7F);
    push_packet(HDR_SYNC | OVF_Y | HDR_BTN, 8'h01, 8'h01);
    push_packet(8'hFF, 8'hFF, 8'hFF);
    push_packet(HDR_SYNC, 8'hFF, 8'hFF);
    push_packet(HDR_SYNC | HDR_XSIGN, 8'h00, 8'hFF);
    drain_block();

    for (int p = 0; p < 5; p++) begin
      write_size(REG_WIDTH, widths[p]);
      write_size(REG_HEIGHT, heights[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      fill_random(ITEMS_PER_PHASE);
      drain_block();
    end

    if (cursor_due.size() != 0) report_mismatch("beats never seen", 0, cursor_due.size());
    if (errors == 0) begin
      $display("[ps2_mouse_packet_cursor_tracker] OK");
    end else begin
      $display("[ps2_mouse_packet_cursor_tracker] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/ps2mt_pkg.sv
design/ps2mt_decode.sv
design/ps2mt_cursor.sv
design/ps2_mouse_packet_cursor_tracker.sv
tb/tb_ps2_mouse_packet_cursor_tracker.sv
